// ===== rtl/websocket_frame_deframer_core_defines.svh =====
// Assertion macros used by the deframer parser RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsfd_pkg.sv =====
// Types and constants shared by the WebSocket deframer modules.
package wsfd_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Header field constants.
    localparam logic [7:0] RSV_BITS    = 8'h70;
    localparam logic [6:0] LEN_CODE16  = 7'd126;
    localparam logic [6:0] LEN_CODE64  = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // One result word.
    typedef struct packed {
        logic [1:0]  item_kind;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        masked_flag;
        logic [63:0] payload_length;
        logic [31:0] masking_key;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

endpackage

// ===== rtl/websocket_frame_deframer_core.sv =====
// Top level of the WebSocket receive deframer: input register, parser, output register.
//
// The block takes one byte of a received WebSocket stream per word and returns
// at most one result word per byte: a header word once the frame header
// (including any extended length and masking key) is complete, one word per
// payload byte (passed through as received, with last on the final byte), or a
// single error word when a first header byte has a reserved bit set, after
// which all bytes are dropped until reset. It sustains one byte per clock
// while m_ready is high. An accepted byte is held in the input register, the
// parser step works on it combinationally, and its result is loaded into the
// output register once that register is free; the m_ side shows the output
// register. While m_ready is low and both registers hold a word, s_ready drops.
// The rate is set by the combinational parser step, which updates the phase
// and the 64-bit remaining-byte counter for each byte.
module websocket_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_item_kind,
    output logic        m_fin_flag,
    output logic [3:0]  m_frame_opcode,
    output logic        m_masked_flag,
    output logic [63:0] m_payload_length,
    output logic [31:0] m_masking_key,
    output logic [7:0]  m_data_byte,
    output logic        m_last
);
    import wsfd_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       out_free;
    logic       fire;
    logic       s_accept;
    logic       res_valid;
    result_t    res;

    // The parser step runs when the input register holds a byte and the output register can take its result.
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    wsfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input word register control.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Output word register control.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_rx_byte;
        end
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_item_kind      = out_reg.item_kind;
    assign m_fin_flag       = out_reg.fin_flag;
    assign m_frame_opcode   = out_reg.frame_opcode;
    assign m_masked_flag    = out_reg.masked_flag;
    assign m_payload_length = out_reg.payload_length;
    assign m_masking_key    = out_reg.masking_key;
    assign m_data_byte      = out_reg.data_byte;
    assign m_last           = out_reg.last;

endmodule

// ===== rtl/wsfd_parser.sv =====
// Frame header parser and payload counter: one byte per enabled cycle.
`include "websocket_frame_deframer_core_defines.svh"

module wsfd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output wsfd_pkg::result_t res
);
    import wsfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remaining_reg, remaining_next;

    logic [6:0]  len7;
    logic [63:0] len_shift;
    logic [31:0] key_shift;
    logic [3:0]  count_dec;
    logic        count_done;
    logic        reserved_set;
    logic        rem_last;

    // Byte-wise shift of the length and key fields, big-endian.
    assign len7         = rx_byte[6:0];
    assign len_shift    = {len_reg[55:0], rx_byte};
    assign key_shift    = {key_reg[23:0], rx_byte};
    assign count_dec    = count_reg - 4'd1;
    assign count_done   = (count_dec == 4'd0);
    assign reserved_set = ((rx_byte & RSV_BITS) != 8'h00);
    assign rem_last     = (remaining_reg == 64'd1);

    // Next-state logic.
    always_comb begin
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        mask_next      = mask_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        remaining_next = remaining_reg;
        if (fire) begin
            case (phase_reg)
                PH_FIRST: begin
                    if (reserved_set) begin
                        phase_next = PH_ERROR;
                    end else begin
                        fin_next    = rx_byte[7];
                        opcode_next = rx_byte[3:0];
                        phase_next  = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    mask_next = rx_byte[7];
                    key_next  = '0;
                    if (len7 == LEN_CODE16) begin
                        len_next   = '0;
                        count_next = EXT16_BYTES;
                        phase_next = PH_EXTLEN;
                    end else if (len7 == LEN_CODE64) begin
                        len_next   = '0;
                        count_next = EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end else begin
                        len_next   = {57'd0, len7};
                        count_next = 4'd0;
                        if (rx_byte[7]) begin
                            count_next = KEY_BYTES;
                            phase_next = PH_KEY;
                        end else if (len7 == 7'd0) begin
                            phase_next = PH_FIRST;
                        end else begin
                            remaining_next = {57'd0, len7};
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXTLEN: begin
                    len_next   = len_shift;
                    count_next = count_dec;
                    if (count_done) begin
                        if (mask_reg) begin
                            count_next = KEY_BYTES;
                            phase_next = PH_KEY;
                        end else if (len_shift == 64'd0) begin
                            phase_next = PH_FIRST;
                        end else begin
                            remaining_next = len_shift;
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                end
                PH_KEY: begin
                    key_next   = key_shift;
                    count_next = count_dec;
                    if (count_done) begin
                        if (len_reg == 64'd0) begin
                            phase_next = PH_FIRST;
                        end else begin
                            remaining_next = len_reg;
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    remaining_next = remaining_reg - 64'd1;
                    if (rem_last) begin
                        phase_next = PH_FIRST;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result logic.
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        if (fire) begin
            case (phase_reg)
                PH_FIRST: begin
                    if (reserved_set) begin
                        res_valid     = 1'b1;
                        res.item_kind = KIND_ERROR;
                    end
                end
                PH_SECOND: begin
                    // Short unmasked length finishes the header right here.
                    if (!rx_byte[7] && len7 != LEN_CODE16 && len7 != LEN_CODE64) begin
                        res_valid          = 1'b1;
                        res.item_kind      = KIND_HEADER;
                        res.fin_flag       = fin_reg;
                        res.frame_opcode   = opcode_reg;
                        res.payload_length = {57'd0, len7};
                        res.last           = (len7 == 7'd0);
                    end
                end
                PH_EXTLEN: begin
                    if (count_done && !mask_reg) begin
                        res_valid          = 1'b1;
                        res.item_kind      = KIND_HEADER;
                        res.fin_flag       = fin_reg;
                        res.frame_opcode   = opcode_reg;
                        res.payload_length = len_shift;
                        res.last           = (len_shift == 64'd0);
                    end
                end
                PH_KEY: begin
                    if (count_done) begin
                        res_valid          = 1'b1;
                        res.item_kind      = KIND_HEADER;
                        res.fin_flag       = fin_reg;
                        res.frame_opcode   = opcode_reg;
                        res.masked_flag    = mask_reg;
                        res.payload_length = len_reg;
                        res.masking_key    = mask_reg ? key_shift : 32'd0;
                        res.last           = (len_reg == 64'd0);
                    end
                end
                PH_PAYLOAD: begin
                    res_valid          = 1'b1;
                    res.item_kind      = KIND_PAYLOAD;
                    res.fin_flag       = fin_reg;
                    res.frame_opcode   = opcode_reg;
                    res.masked_flag    = mask_reg;
                    res.payload_length = len_reg;
                    res.masking_key    = mask_reg ? key_reg : 32'd0;
                    res.data_byte      = rx_byte;
                    res.last           = rem_last;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FIRST;
            fin_reg       <= 1'b0;
            opcode_reg    <= 4'd0;
            mask_reg      <= 1'b0;
            len_reg       <= 64'd0;
            count_reg     <= 4'd0;
            key_reg       <= 32'd0;
            remaining_reg <= 64'd0;
        end else begin
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            key_reg       <= key_next;
            remaining_reg <= remaining_next;
        end
    end

    // Checks on the parser state.
    `WFD_ASSERT_IMP(a_error_silent, aclk, aresetn,
        phase_reg == PH_ERROR, !res_valid, "result after error")
    `WFD_ASSERT_IMP(a_payload_nonzero, aclk, aresetn,
        phase_reg == PH_PAYLOAD, remaining_reg != 64'd0, "payload phase with zero count")
    `WFD_ASSERT_IMP(a_field_count, aclk, aresetn,
        phase_reg == PH_EXTLEN || phase_reg == PH_KEY, count_reg != 4'd0,
        "field phase with zero count")
    `WFD_ASSERT_NEXT(a_header_to_payload, aclk, aresetn,
        fire && res_valid && res.item_kind == KIND_HEADER && !res.last,
        phase_reg == PH_PAYLOAD && remaining_reg == $past(res.payload_length),
        "header did not start payload")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the WebSocket receive deframer core.
`timescale 1ns / 100ps

module tb;
    import wsfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int WORDS_PER_PHASE = 450;
    localparam int DRAIN_CYCLES = 20;
    // The reserved-bit error locks the parser until reset, so the last rows
    // of the directed table are only sent after all other traffic.
    localparam int LOCKOUT_ROWS = 3;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        result_t    res;
    } stim_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_item_kind;
    logic        m_fin_flag;
    logic [3:0]  m_frame_opcode;
    logic        m_masked_flag;
    logic [63:0] m_payload_length;
    logic [31:0] m_masking_key;
    logic [7:0]  m_data_byte;
    logic        m_last;

    stim_t   directed_rows[$];
    stim_t   byte_feed[$];
    result_t expected_words[$];
    stim_t   presented;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // Predictor state for the frame parser.
    phase_t      prd_phase = PH_FIRST;
    logic        prd_fin = 1'b0;
    logic [3:0]  prd_opcode = 4'd0;
    logic        prd_mask = 1'b0;
    logic [63:0] prd_length = 64'd0;
    logic [3:0]  prd_count = 4'd0;
    logic [31:0] prd_key = 32'd0;
    logic [63:0] prd_remaining = 64'd0;

    websocket_frame_deframer_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_fin_flag      (m_fin_flag),
        .m_frame_opcode  (m_frame_opcode),
        .m_masked_flag   (m_masked_flag),
        .m_payload_length(m_payload_length),
        .m_masking_key   (m_masking_key),
        .m_data_byte     (m_data_byte),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic result_t make_word(logic [1:0] kind, logic fin, logic [3:0] op,
                                          logic msk, logic [63:0] len, logic [31:0] key,
                                          logic [7:0] data, logic lst);
        result_t r;
        r.item_kind      = kind;
        r.fin_flag       = fin;
        r.frame_opcode   = op;
        r.masked_flag    = msk;
        r.payload_length = len;
        r.masking_key    = key;
        r.data_byte      = data;
        r.last           = lst;
        return r;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Header word for the current frame; moves on to the payload or the next frame.
    task close_header(output result_t r);
        r = make_word(KIND_HEADER, prd_fin, prd_opcode, prd_mask, prd_length,
                      prd_mask ? prd_key : 32'd0, 8'd0, prd_length == 64'd0);
        if (prd_length == 64'd0) begin
            prd_phase = PH_FIRST;
        end else begin
            prd_remaining = prd_length;
            prd_phase = PH_PAYLOAD;
        end
    endtask

    // Expected parser response to one received word.
    task deframe_step(input logic [7:0] b, output bit got, output result_t r);
        got = 1'b0;
        r = '0;
        case (prd_phase)
            PH_FIRST: begin
                if ((b & RSV_BITS) != 8'd0) begin
                    r = make_word(KIND_ERROR, 1'b0, 4'd0, 1'b0, 64'd0, 32'd0, 8'd0, 1'b0);
                    got = 1'b1;
                    prd_phase = PH_ERROR;
                end else begin
                    prd_fin = b[7];
                    prd_opcode = b[3:0];
                    prd_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                prd_mask = b[7];
                prd_key = 32'd0;
                prd_length = 64'd0;
                if (b[6:0] == LEN_CODE16) begin
                    prd_count = EXT16_BYTES;
                    prd_phase = PH_EXTLEN;
                end else if (b[6:0] == LEN_CODE64) begin
                    prd_count = EXT64_BYTES;
                    prd_phase = PH_EXTLEN;
                end else begin
                    prd_length = {57'd0, b[6:0]};
                    prd_count = 4'd0;
                    if (prd_mask) begin
                        prd_count = KEY_BYTES;
                        prd_phase = PH_KEY;
                    end else begin
                        close_header(r);
                        got = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                prd_length = {prd_length[55:0], b};
                prd_count = prd_count - 4'd1;
                if (prd_count == 4'd0) begin
                    if (prd_mask) begin
                        prd_count = KEY_BYTES;
                        prd_phase = PH_KEY;
                    end else begin
                        close_header(r);
                        got = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                prd_key = {prd_key[23:0], b};
                prd_count = prd_count - 4'd1;
                if (prd_count == 4'd0) begin
                    close_header(r);
                    got = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                prd_remaining = prd_remaining - 64'd1;
                r = make_word(KIND_PAYLOAD, prd_fin, prd_opcode, prd_mask, prd_length,
                              prd_mask ? prd_key : 32'd0, b, prd_remaining == 64'd0);
                got = 1'b1;
                if (prd_remaining == 64'd0) begin
                    prd_phase = PH_FIRST;
                end
            end
            default: begin
                got = 1'b0;
            end
        endcase
    endtask

    task add_row(input logic [7:0] b);
        stim_t s;
        s.rx = b;
        s.typed = 1'b0;
        s.res = '0;
        directed_rows.push_back(s);
    endtask

    task add_typed_row(input logic [7:0] b, input result_t r);
        stim_t s;
        s.rx = b;
        s.typed = 1'b1;
        s.res = r;
        directed_rows.push_back(s);
    endtask

    task feed(input logic [7:0] b);
        stim_t s;
        s.rx = b;
        s.typed = 1'b0;
        s.res = '0;
        byte_feed.push_back(s);
    endtask

    // One well-formed frame with random header fields and payload.
    task queue_frame(output int pushed);
        int          sel;
        int          plen;
        logic        msk;
        logic [6:0]  code;
        logic [63:0] ext;
        logic [31:0] key;
        sel = $urandom_range(0, 99);
        msk = 1'($urandom_range(0, 1));
        key = $urandom;
        pushed = 0;
        if (sel < 10) begin
            plen = 0;
        end else if (sel < 60) begin
            plen = $urandom_range(1, 16);
        end else if (sel < 75) begin
            plen = $urandom_range(17, 125);
        end else begin
            plen = $urandom_range(0, 200);
        end
        code = (sel < 75) ? 7'(plen) : ((sel < 88) ? LEN_CODE16 : LEN_CODE64);
        ext = 64'(plen);
        feed({1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))});
        feed({msk, code});
        pushed += 2;
        if (code == LEN_CODE16) begin
            feed(ext[15:8]);
            feed(ext[7:0]);
            pushed += 2;
        end else if (code == LEN_CODE64) begin
            for (int i = 7; i >= 0; i--) begin
                feed(ext[i*8 +: 8]);
            end
            pushed += 8;
        end
        if (msk) begin
            for (int i = 3; i >= 0; i--) begin
                feed(key[i*8 +: 8]);
            end
            pushed += 4;
        end
        for (int i = 0; i < plen; i++) begin
            feed(8'($urandom));
        end
        pushed += plen;
    endtask

    task drain_feed;
        while (byte_feed.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
    endtask

    task check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    // Input side: predict each accepted word, then present the next one.
    always @(posedge aclk) begin : drive_proc
        bit      accepted;
        bit      got;
        result_t pred;
        if (aresetn) begin
            accepted = s_valid && s_ready;
            if (accepted) begin
                deframe_step(s_rx_byte, got, pred);
                if (presented.typed) begin
                    expected_words.push_back(presented.res);
                end else if (got) begin
                    expected_words.push_back(pred);
                end
            end
            if (!s_valid || accepted) begin
                if (byte_feed.size() > 0 && !roll(send_idle_pct)) begin
                    presented = byte_feed.pop_front();
                    s_valid <= 1'b1;
                    s_rx_byte <= presented.rx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: compare each accepted word with the oldest expectation.
    always @(posedge aclk) begin : sink_proc
        result_t want;
        result_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen = {m_item_kind, m_fin_flag, m_frame_opcode, m_masked_flag,
                        m_payload_length, m_masking_key, m_data_byte, m_last};
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none actual %h",
                             $time, seen);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("item_kind", want.item_kind, seen.item_kind);
                    check_field("fin_flag", want.fin_flag, seen.fin_flag);
                    check_field("frame_opcode", want.frame_opcode, seen.frame_opcode);
                    check_field("masked_flag", want.masked_flag, seen.masked_flag);
                    check_field("payload_length", want.payload_length,
                                seen.payload_length);
                    check_field("masking_key", want.masking_key, seen.masking_key);
                    check_field("data_byte", want.data_byte, seen.data_byte);
                    check_field("last", want.last, seen.last);
                end
            end
            m_ready <= !roll(recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("websocket_frame_deframer_core regression: fail");
            $finish;
        end
    end

    initial begin : main_proc
        int pushed;
        int total;

        // Empty frame with FIN and a text opcode.
        add_row(8'h81);
        add_typed_row(8'h00, make_word(KIND_HEADER, 1'b1, 4'h1, 1'b0, 64'd0, 32'd0,
                                       8'd0, 1'b1));
        // All opcode bits set, masked, one payload word of all ones.
        add_row(8'h8F);
        add_row(8'h81);
        add_row(8'hFF);
        add_row(8'h00);
        add_row(8'hA5);
        add_typed_row(8'h5A, make_word(KIND_HEADER, 1'b1, 4'hF, 1'b1, 64'd1, 32'hFF00A55A,
                                       8'd0, 1'b0));
        add_typed_row(8'hFF, make_word(KIND_PAYLOAD, 1'b1, 4'hF, 1'b1, 64'd1, 32'hFF00A55A,
                                       8'hFF, 1'b1));
        // Sixteen-bit length code, continuation opcode, no FIN.
        add_row(8'h00);
        add_row(8'h7E);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h7F);
        // Sixty-four-bit length code carrying a zero length.
        add_row(8'h02);
        add_row(8'h7F);
        for (int i = 0; i < 7; i++) begin
            add_row(8'h00);
        end
        add_typed_row(8'h00, make_word(KIND_HEADER, 1'b0, 4'h2, 1'b0, 64'd0, 32'd0,
                                       8'd0, 1'b1));
        // Reserved bit in a first header word, then words that must be dropped.
        add_typed_row(8'hF0, make_word(KIND_ERROR, 1'b0, 4'd0, 1'b0, 64'd0, 32'd0,
                                       8'd0, 1'b0));
        add_row(8'h81);
        add_row(8'h00);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < directed_rows.size() - LOCKOUT_ROWS; i++) begin
            byte_feed.push_back(directed_rows[i]);
        end
        drain_feed();

        // Random frames under each idling pattern in turn.
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            total = 0;
            while (total < WORDS_PER_PHASE) begin
                queue_frame(pushed);
                total += pushed;
            end
            drain_feed();
        end

        for (int i = directed_rows.size() - LOCKOUT_ROWS; i < directed_rows.size(); i++) begin
            byte_feed.push_back(directed_rows[i]);
        end
        drain_feed();

        while (expected_words.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("websocket_frame_deframer_core regression: pass");
        end else begin
            $display("websocket_frame_deframer_core regression: fail");
        end
        $finish;
    end

endmodule
